FILE: rtl/jss_pkg.sv
package jss_pkg;

   localparam int MAX_DIM   = 1024;
   localparam int IDX_W     = $clog2(MAX_DIM);
   localparam int DIM_W     = IDX_W + 1;
   localparam int CFG_DIM_W = 11;
   localparam int VAL_W     = 32;
   localparam int SUM_W     = VAL_W + 2;
   localparam int PROD_W    = 2 * VAL_W + 1;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_TILE_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_COLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_H_SQUARED = 2'd2;

   localparam logic [DIM_W-1:0] DIM_MIN     = DIM_W'(3);
   localparam logic [DIM_W-1:0] DIM_MAX     = DIM_W'(MAX_DIM);
   localparam logic [VAL_W-1:0] H_SQ_RESET  = 32'h4000_0000;

   typedef struct packed {
      logic signed [VAL_W-1:0] old_value;
      logic signed [VAL_W-1:0] source_value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] new_value;
      logic [IDX_W-1:0]        point_row;
      logic [IDX_W-1:0]        point_col;
      logic                    tile_done;
   } rsp_type;

   // one column of the line stores
   typedef struct packed {
      logic [VAL_W-1:0] prev_row;
      logic [VAL_W-1:0] older_row;
      logic [VAL_W-1:0] prev_source;
   } line_word_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum_bias;
      logic signed [VAL_W-1:0] source;
      logic [VAL_W-1:0]        h_squared;
      logic [IDX_W-1:0]        point_row;
      logic [IDX_W-1:0]        point_col;
      logic                    tile_done;
   } stencil_op_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (int'(v) < int'(DIM_MIN)) begin
         r = DIM_MIN;
      end else if (int'(v) > MAX_DIM) begin
         r = DIM_MAX;
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   function automatic logic signed [SUM_W-1:0] sext_sum(input logic [VAL_W-1:0] v);
      return {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
   endfunction

endpackage

FILE: rtl/jss_ram.sv
module jss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/jss_stencil.sv
module jss_stencil (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    issue_valid,
   input  jss_pkg::stencil_op_type issue_op,
   output logic                    issue_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output jss_pkg::rsp_type        rsp_data
);

   typedef struct packed {
      logic signed [jss_pkg::SUM_W-1:0]  sum_bias;
      logic signed [jss_pkg::PROD_W-1:0] prod;
      logic [jss_pkg::IDX_W-1:0]         point_row;
      logic [jss_pkg::IDX_W-1:0]         point_col;
      logic                              tile_done;
   } mul_type;

   localparam int T_W = jss_pkg::SUM_W + jss_pkg::VAL_W + 1;
   localparam int Q_W = T_W - (jss_pkg::VAL_W + 2);

   logic                    s1_v_ff, s2_v_ff, s3_v_ff;
   jss_pkg::stencil_op_type s1_ff;
   mul_type                 s2_ff, s2_in;
   jss_pkg::rsp_type        s3_ff, s3_in;
   logic                    en1, en2, en3;

   logic signed [jss_pkg::VAL_W:0] h_signed;
   logic signed [T_W-1:0]          t_val;
   logic signed [Q_W-1:0]          q_val;

   assign en3 = !s3_v_ff || !rsp_stall;
   assign en2 = !s2_v_ff || en3;
   assign en1 = !s1_v_ff || en2;
   assign issue_ready = en1;

   // h_squared is unsigned, so the product takes it with a zero sign bit
   always_comb begin
      h_signed        = {1'b0, s1_ff.h_squared};
      s2_in.sum_bias  = s1_ff.sum_bias;
      s2_in.prod      = s1_ff.source * h_signed;
      s2_in.point_row = s1_ff.point_row;
      s2_in.point_col = s1_ff.point_col;
      s2_in.tile_done = s1_ff.tile_done;
   end

   // (sum + 2) * 2^32 - f*h, floor divided by 2^34 gives round half up of a quarter
   always_comb begin
      t_val = {s2_ff.sum_bias[jss_pkg::SUM_W-1], s2_ff.sum_bias, {jss_pkg::VAL_W{1'b0}}}
            - T_W'(s2_ff.prod);
      q_val = t_val[T_W-1:jss_pkg::VAL_W+2];
      if (q_val[Q_W-1] != q_val[Q_W-2]) begin
         s3_in.new_value = q_val[Q_W-1] ? {1'b1, {(jss_pkg::VAL_W-1){1'b0}}}
                                        : {1'b0, {(jss_pkg::VAL_W-1){1'b1}}};
      end else begin
         s3_in.new_value = q_val[jss_pkg::VAL_W-1:0];
      end
      s3_in.point_row = s2_ff.point_row;
      s3_in.point_col = s2_ff.point_col;
      s3_in.tile_done = s2_ff.tile_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         if (en1) begin
            s1_v_ff <= issue_valid;
         end
         if (en2) begin
            s2_v_ff <= s1_v_ff;
         end
         if (en3) begin
            s3_v_ff <= s2_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff <= issue_op;
      end
      if (en2) begin
         s2_ff <= s2_in;
      end
      if (en3) begin
         s3_ff <= s3_in;
      end
   end

   assign rsp_valid = s3_v_ff;
   assign rsp_data  = s3_ff;

endmodule

FILE: rtl/jacobi_stencil_sweep.sv
// Jacobi 5-point stencil sweep over a raster stream of one tile (ghost ring included).
// One transaction is taken every cycle unless stalled; each point from the third row on,
// in an interior column, returns the update of the point above it through the pipeline;
// results keep the order of the stream. Row and column counts take effect at the next
// transaction and restart the tile; h_squared takes effect at the next transaction. The
// line stores live in one 1024 x 96 RAM with one write and one registered read per
// cycle; reads run two columns ahead of the stream, so the first two rows of each tile
// only fill the stores and give no result. The stores are not cleared after reset.
module jacobi_stencil_sweep (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  jss_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output jss_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [jss_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [jss_pkg::VAL_W-1:0]         csr_wdata
);

   localparam int LINE_W = $bits(jss_pkg::line_word_type);

   logic [jss_pkg::DIM_W-1:0] rows_ff, cols_ff;
   logic [jss_pkg::VAL_W-1:0] h_sq_ff;
   logic [jss_pkg::IDX_W-1:0] row_ff, col_ff, row_in, col_in;

   // window on the previous row: left column, current column, and the ram output
   logic [jss_pkg::VAL_W-1:0] left_ff;
   jss_pkg::line_word_type    mid_ff;
   jss_pkg::line_word_type    ahead;
   jss_pkg::line_word_type    wr_word;
   logic [LINE_W-1:0]         ram_rd_data;

   logic                      accept, csr_write, restart, emit, last_point, pipe_ready;
   logic [jss_pkg::DIM_W-1:0] row_ext, col_ext, col_p1, col_p2, col_wrap;
   logic [jss_pkg::IDX_W-1:0] rd_addr;
   jss_pkg::stencil_op_type   op;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign restart   = csr_write
                    && (csr_index inside {jss_pkg::CSR_TILE_ROWS, jss_pkg::CSR_TILE_COLS});
   assign req_stall = !pipe_ready;
   assign accept    = req_valid && !req_stall;
   assign ahead     = jss_pkg::line_word_type'(ram_rd_data);

   always_comb begin
      row_ext    = {1'b0, row_ff};
      col_ext    = {1'b0, col_ff};
      col_p1     = col_ext + jss_pkg::DIM_W'(1);
      col_p2     = col_ext + jss_pkg::DIM_W'(2);
      col_wrap   = col_p2 - cols_ff;
      emit       = (row_ff >= jss_pkg::IDX_W'(2)) && (col_ff != '0) && (col_p2 <= cols_ff);
      last_point = ((row_ext + jss_pkg::DIM_W'(1)) == rows_ff) && (col_p2 == cols_ff);
      // next read serves the transaction two columns on, wrapping into the next row
      if (col_p2 < cols_ff) begin
         rd_addr = col_p2[jss_pkg::IDX_W-1:0];
      end else begin
         rd_addr = col_wrap[jss_pkg::IDX_W-1:0];
      end
      if (col_p1 >= cols_ff) begin
         col_in = '0;
         if ((row_ext + jss_pkg::DIM_W'(1)) >= rows_ff) begin
            row_in = '0;
         end else begin
            row_in = row_ff + jss_pkg::IDX_W'(1);
         end
      end else begin
         col_in = col_p1[jss_pkg::IDX_W-1:0];
         row_in = row_ff;
      end
   end

   always_comb begin
      op.sum_bias  = jss_pkg::sext_sum(mid_ff.older_row) + jss_pkg::sext_sum(left_ff)
                   + jss_pkg::sext_sum(ahead.prev_row) + jss_pkg::sext_sum(req_data.old_value)
                   + jss_pkg::SUM_W'(2);
      op.source    = mid_ff.prev_source;
      op.h_squared = h_sq_ff;
      op.point_row = row_ff - jss_pkg::IDX_W'(1);
      op.point_col = col_ff;
      op.tile_done = last_point;

      wr_word.prev_row    = req_data.old_value;
      wr_word.older_row   = mid_ff.prev_row;
      wr_word.prev_source = req_data.source_value;
   end

   jss_ram #(
      .WIDTH (LINE_W),
      .DEPTH (jss_pkg::MAX_DIM)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (wr_word),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   jss_stencil u_stencil (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (accept && emit),
      .issue_op    (op),
      .issue_ready (pipe_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= jss_pkg::DIM_MIN;
         cols_ff <= jss_pkg::DIM_MIN;
         h_sq_ff <= jss_pkg::H_SQ_RESET;
         row_ff  <= '0;
         col_ff  <= '0;
      end else begin
         // a size write restarts the tile, even alongside a transaction
         if (restart) begin
            row_ff <= '0;
            col_ff <= '0;
         end else if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         if (csr_write) begin
            case (csr_index)
               jss_pkg::CSR_TILE_ROWS: begin
                  rows_ff <= jss_pkg::clamp_dim(csr_wdata[jss_pkg::CFG_DIM_W-1:0]);
               end
               jss_pkg::CSR_TILE_COLS: begin
                  cols_ff <= jss_pkg::clamp_dim(csr_wdata[jss_pkg::CFG_DIM_W-1:0]);
               end
               jss_pkg::CSR_H_SQUARED: begin
                  h_sq_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         left_ff <= mid_ff.prev_row;
         mid_ff  <= ahead;
      end
   end

endmodule

FILE: rtl/jss_checker.sv
module jss_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input jss_pkg::rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // nothing can block the input while the output stage is empty
   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

   a_interior_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.point_row != '0) && (rsp_data.point_col != '0))
      else $error("result for a ghost point");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind jacobi_stencil_sweep jss_checker u_jss_checker (.*);

FILE: verif/jacobi_stencil_sweep_tb.sv
module jacobi_stencil_sweep_tb;

   // index past the decoded registers, writes to it must be dropped
   localparam logic [jss_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 60;
   localparam int REPORT_LIMIT  = 10;
   localparam logic signed [71:0] Q_MAX = 72'sd2147483647;
   localparam logic signed [71:0] Q_MIN = -72'sd2147483648;

   typedef enum int {VAL_FULL, VAL_SMALL, VAL_EDGE, VAL_MIXED} value_mix_type;
   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   jss_pkg::req_type              req_data;
   logic                          rsp_valid;
   logic                          rsp_stall;
   jss_pkg::rsp_type              rsp_data;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [jss_pkg::CSR_IDX_W-1:0] csr_index;
   logic [jss_pkg::VAL_W-1:0]     csr_wdata;

   // shadow copy of the sweep state
   logic [jss_pkg::CFG_DIM_W-1:0] cfg_rows;
   logic [jss_pkg::CFG_DIM_W-1:0] cfg_cols;
   logic [jss_pkg::VAL_W-1:0]     cfg_h_sq;
   int unsigned                   grid_row;
   int unsigned                   grid_col;
   logic [jss_pkg::VAL_W-1:0]     line_prev [jss_pkg::MAX_DIM];
   logic [jss_pkg::VAL_W-1:0]     line_older [jss_pkg::MAX_DIM];
   logic [jss_pkg::VAL_W-1:0]     line_source [jss_pkg::MAX_DIM];
   jss_pkg::rsp_type              pending_points[$];
   jss_pkg::rsp_type              head_point;

   int unsigned points_sent;
   int unsigned points_checked;
   int unsigned tiles_closed;
   int unsigned mismatch_count;
   int unsigned reported;
   int unsigned burst_left;
   int unsigned csr_writes;

   stall_mode_type stall_mode;
   int unsigned    stall_left;
   int unsigned    run_left;
   logic           stall_level;

   jacobi_stencil_sweep DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("jacobi_stencil_sweep_tb: done, errors");
      $finish;
   end

   function automatic int unsigned eff_dim(input logic [jss_pkg::CFG_DIM_W-1:0] v);
      if (v < 3) return 3;
      if (v > jss_pkg::MAX_DIM) return jss_pkg::MAX_DIM;
      return 32'(v);
   endfunction

   // quarter of (neighbour sum - h*f), round half up, saturate to q16.16
   function automatic logic [jss_pkg::VAL_W-1:0] jacobi_update(
      input logic signed [jss_pkg::VAL_W-1:0] north,
      input logic signed [jss_pkg::VAL_W-1:0] south,
      input logic signed [jss_pkg::VAL_W-1:0] west,
      input logic signed [jss_pkg::VAL_W-1:0] east,
      input logic signed [jss_pkg::VAL_W-1:0] f,
      input logic [jss_pkg::VAL_W-1:0]        h
   );
      logic signed [71:0] acc;
      logic signed [71:0] hf;
      logic signed [71:0] num;
      acc = 72'(north);
      acc = acc + 72'(south);
      acc = acc + 72'(west);
      acc = acc + 72'(east);
      hf  = $signed({40'd0, h}) * 72'(f);
      num = (acc <<< 32) - hf + (72'sd1 <<< 33);
      num = num >>> 34;
      if (num > Q_MAX) num = Q_MAX;
      if (num < Q_MIN) num = Q_MIN;
      return num[jss_pkg::VAL_W-1:0];
   endfunction

   function automatic void advance_grid(input jss_pkg::req_type pt);
      int unsigned      n_rows;
      int unsigned      n_cols;
      int unsigned      r;
      int unsigned      c;
      jss_pkg::rsp_type upd;
      n_rows = eff_dim(cfg_rows);
      n_cols = eff_dim(cfg_cols);
      r = grid_row;
      c = grid_col;
      if (r >= n_rows) r = 0;
      if (c >= n_cols) c = 0;
      if (r >= 2 && c >= 1 && c + 2 <= n_cols) begin
         // west comes from the slot already shifted on this row
         upd.new_value = jacobi_update(line_older[c], pt.old_value, line_older[c-1],
                                       line_prev[c+1], line_source[c], cfg_h_sq);
         upd.point_row = jss_pkg::IDX_W'(r - 1);
         upd.point_col = jss_pkg::IDX_W'(c);
         upd.tile_done = (r + 1 == n_rows) && (c + 2 == n_cols);
         pending_points.push_back(upd);
      end
      line_older[c]  = line_prev[c];
      line_prev[c]   = pt.old_value;
      line_source[c] = pt.source_value;
      c++;
      if (c >= n_cols) begin
         c = 0;
         r++;
         if (r >= n_rows) r = 0;
      end
      grid_row = r;
      grid_col = c;
   endfunction

   function automatic logic [jss_pkg::VAL_W-1:0] pick_sample(input value_mix_type mix);
      value_mix_type             m;
      logic [jss_pkg::VAL_W-1:0] v;
      m = mix;
      if (m == VAL_MIXED) m = value_mix_type'($urandom_range(0, 2));
      case (m)
         VAL_FULL:  v = $urandom;
         VAL_SMALL: v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
         default: begin
            case ($urandom_range(0, 3))
               0:       v = 32'h7FFF_FFFF;
               1:       v = 32'h8000_0000;
               2:       v = 32'h0000_0000;
               default: v = 32'hFFFF_FFFF;
            endcase
         end
      endcase
      return v;
   endfunction

   function automatic logic [jss_pkg::VAL_W-1:0] pick_h();
      longint unsigned n;
      case ($urandom_range(0, 4))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return jss_pkg::H_SQ_RESET;
         3: return $urandom;
         default: begin
            // realistic spacing 1/(n+1)^2
            n = $urandom_range(1, 200);
            return jss_pkg::VAL_W'(64'h1_0000_0000 / ((n + 1) * (n + 1)));
         end
      endcase
   endfunction

   function automatic logic [jss_pkg::CFG_DIM_W-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0:       return jss_pkg::CFG_DIM_W'($urandom_range(0, 2));
         1:       return jss_pkg::CFG_DIM_W'($urandom_range(11, 16));
         default: return jss_pkg::CFG_DIM_W'($urandom_range(3, 8));
      endcase
   endfunction

   task automatic settle_stream();
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_point(input jss_pkg::req_type pt);
      req_valid <= 1'b1;
      req_data  <= pt;
      do @(posedge clock); while (req_stall);
      advance_grid(pt);
      points_sent++;
      @(negedge clock);
      burst_left--;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic write_reg(input logic [jss_pkg::CSR_IDX_W-1:0] idx,
                            input logic [jss_pkg::VAL_W-1:0]     value);
      settle_stream();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         jss_pkg::CSR_TILE_ROWS: begin
            cfg_rows = value[jss_pkg::CFG_DIM_W-1:0];
            grid_row = 0;
            grid_col = 0;
         end
         jss_pkg::CSR_TILE_COLS: begin
            cfg_cols = value[jss_pkg::CFG_DIM_W-1:0];
            grid_row = 0;
            grid_col = 0;
         end
         jss_pkg::CSR_H_SQUARED: cfg_h_sq = value;
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic feed_points(input int unsigned n, input value_mix_type mix);
      jss_pkg::req_type pt;
      for (int unsigned i = 0; i < n; i++) begin
         pt.old_value    = pick_sample(mix);
         pt.source_value = pick_sample(mix);
         send_point(pt);
      end
   endtask

   // single-point 3x3 tiles driven to both rails
   task automatic test_saturation();
      jss_pkg::req_type pt;
      pt.old_value    = 32'h7FFF_FFFF;
      pt.source_value = 32'h8000_0000;
      repeat (9) send_point(pt);
      pt.old_value    = 32'h8000_0000;
      pt.source_value = 32'h7FFF_FFFF;
      repeat (9) send_point(pt);
   endtask

   task automatic test_size_clamp();
      write_reg(CSR_SPARE, $urandom);
      write_reg(jss_pkg::CSR_TILE_COLS, 32'd2047);
      write_reg(jss_pkg::CSR_TILE_COLS, 32'd1);
      write_reg(jss_pkg::CSR_TILE_ROWS, 32'd0);
      feed_points(18, VAL_MIXED);
      write_reg(jss_pkg::CSR_TILE_ROWS, 32'd2);
      write_reg(jss_pkg::CSR_TILE_COLS, 32'd2);
      feed_points(9, VAL_FULL);
   endtask

   task automatic test_restart();
      write_reg(jss_pkg::CSR_TILE_ROWS, 32'd5);
      write_reg(jss_pkg::CSR_TILE_COLS, 32'd6);
      feed_points(17, VAL_MIXED);
      write_reg(jss_pkg::CSR_TILE_COLS, 32'd7);
      feed_points(45, VAL_MIXED);
      write_reg(jss_pkg::CSR_TILE_ROWS, 32'd4);
      feed_points(28, VAL_SMALL);
      // spacing change mid tile keeps the position
      feed_points(5, VAL_FULL);
      write_reg(jss_pkg::CSR_H_SQUARED, pick_h());
      feed_points(23, VAL_FULL);
   endtask

   task automatic test_h_squared();
      write_reg(jss_pkg::CSR_TILE_ROWS, 32'd4);
      write_reg(jss_pkg::CSR_TILE_COLS, 32'd5);
      write_reg(jss_pkg::CSR_H_SQUARED, 32'h0000_0000);
      feed_points(20, VAL_FULL);
      write_reg(jss_pkg::CSR_H_SQUARED, 32'hFFFF_FFFF);
      feed_points(20, VAL_EDGE);
      feed_points(20, VAL_FULL);
      write_reg(jss_pkg::CSR_H_SQUARED, jss_pkg::H_SQ_RESET);
      feed_points(20, VAL_MIXED);
   endtask

   // oversized widths and heights clamp to the line store depth, streamed in part
   task automatic test_large_tiles();
      write_reg(jss_pkg::CSR_TILE_ROWS, 32'd3);
      write_reg(jss_pkg::CSR_TILE_COLS, 32'd2047);
      feed_points(40, VAL_MIXED);
      write_reg(jss_pkg::CSR_TILE_COLS, 32'd3);
      write_reg(jss_pkg::CSR_TILE_ROWS, 32'd2047);
      feed_points(60, VAL_MIXED);
   endtask

   task automatic test_random_sweeps();
      int unsigned   start;
      int unsigned   area;
      value_mix_type mix;
      start = points_sent;
      while (points_sent - start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) != 0) begin
            write_reg(jss_pkg::CSR_TILE_ROWS, pick_dim());
            write_reg(jss_pkg::CSR_TILE_COLS, pick_dim());
         end
         if ($urandom_range(0, 1) == 0) write_reg(jss_pkg::CSR_H_SQUARED, pick_h());
         if ($urandom_range(0, 7) == 0) write_reg(CSR_SPARE, $urandom);
         area = eff_dim(cfg_rows) * eff_dim(cfg_cols);
         mix  = value_mix_type'($urandom_range(0, 3));
         // a cut tile resumes where it stopped unless a size write restarts it
         if ($urandom_range(0, 4) == 0) feed_points($urandom_range(1, area), mix);
         else feed_points(area * $urandom_range(1, 2), mix);
         if ($urandom_range(0, 3) == 0) settle_stream();
      end
   endtask

   initial begin
      rsp_stall   = 1'b0;
      stall_mode  = STALL_NONE;
      stall_left  = 0;
      run_left    = 0;
      stall_level = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 2));
            stall_left = $urandom_range(20, 200);
         end
         stall_left--;
         case (stall_mode)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_RANDOM: rsp_stall <= ($urandom_range(0, 99) < 35);
            default: begin
               if (run_left == 0) begin
                  stall_level = ~stall_level;
                  run_left    = $urandom_range(1, 8);
               end
               run_left--;
               rsp_stall <= stall_level;
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            mismatch_count++;
            if (reported < REPORT_LIMIT) begin
               reported++;
               $display("unexpected update: value=%h row=%0d col=%0d done=%0b",
                        rsp_data.new_value, rsp_data.point_row, rsp_data.point_col,
                        rsp_data.tile_done);
            end
         end else begin
            head_point = pending_points.pop_front();
            points_checked++;
            if (rsp_data.tile_done) tiles_closed++;
            if (rsp_data.new_value !== head_point.new_value ||
                rsp_data.point_row !== head_point.point_row ||
                rsp_data.point_col !== head_point.point_col ||
                rsp_data.tile_done !== head_point.tile_done) begin
               mismatch_count++;
               if (reported < REPORT_LIMIT) begin
                  reported++;
                  $display("update mismatch: want value=%h row=%0d col=%0d done=%0b",
                           head_point.new_value, head_point.point_row,
                           head_point.point_col, head_point.tile_done);
                  $display("                  got value=%h row=%0d col=%0d done=%0b",
                           rsp_data.new_value, rsp_data.point_row, rsp_data.point_col,
                           rsp_data.tile_done);
               end
            end
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = jss_pkg::CSR_TILE_ROWS;
      csr_wdata = '0;
      cfg_rows  = jss_pkg::CFG_DIM_W'(3);
      cfg_cols  = jss_pkg::CFG_DIM_W'(3);
      cfg_h_sq  = jss_pkg::H_SQ_RESET;
      grid_row  = 0;
      grid_col  = 0;
      points_sent    = 0;
      points_checked = 0;
      tiles_closed   = 0;
      mismatch_count = 0;
      reported       = 0;
      csr_writes     = 0;
      burst_left     = 1;
      foreach (line_prev[i]) begin
         line_prev[i]   = '0;
         line_older[i]  = '0;
         line_source[i] = '0;
      end
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      test_saturation();
      test_size_clamp();
      test_restart();
      test_h_squared();
      test_large_tiles();
      test_random_sweeps();
      settle_stream();

      $display("sweep run: %0d points streamed, %0d updates checked, %0d tiles closed",
               points_sent, points_checked, tiles_closed);
      $display("%0d csr writes, sizes clamped and restarted; %0d mismatches, %0d missing",
               csr_writes, mismatch_count, pending_points.size());
      if (mismatch_count == 0 && pending_points.size() == 0) begin
         $display("jacobi_stencil_sweep_tb: done, clean");
      end else begin
         $display("jacobi_stencil_sweep_tb: done, errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/jss_pkg.sv
rtl/jss_ram.sv
rtl/jss_stencil.sv
rtl/jacobi_stencil_sweep.sv
rtl/jss_checker.sv
verif/jacobi_stencil_sweep_tb.sv
